// File: rtl/gbfp_pkg.sv
`timescale 1ns / 1ps
// gbfp_pkg: shared types and constants for the binary gnss frame parser
// no dependencies

package gbfp_pkg;

   // framing constants
   localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND   = 8'h62;
   localparam logic [15:0] TYPE_STATUS   = 16'h0103;
   localparam logic [15:0] TYPE_POSITION = 16'h0117;

   // payload word offsets, expressed as offset[15:2]
   localparam logic [13:0] LON_WORD = 14'd7;   // bytes 28..31
   localparam logic [13:0] LAT_WORD = 14'd8;   // bytes 32..35
   localparam logic [15:0] POS_NEED = 16'd36;

   // frame kind codes
   localparam logic [1:0] KIND_POSITION = 2'd0;
   localparam logic [1:0] KIND_STATUS   = 2'd1;
   localparam logic [1:0] KIND_OTHER    = 2'd2;
   localparam logic [1:0] KIND_SHORT    = 2'd3;

   typedef enum logic [3:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_CLASS,
      PH_ID,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_CHK1,
      PH_CHK2
   } phase_type;

   // position capture control from the frame state machine
   typedef struct packed {
      logic       clear;
      logic       lon_we;
      logic       lat_we;
      logic [1:0] lane;
   } capture_ctrl_type;

   // frame summary from the state machine
   typedef struct packed {
      logic        emit;
      logic [1:0]  kind;
      logic [15:0] type_word;
   } frame_info_type;

endpackage

// File: rtl/gbfp_if.sv
`timescale 1ns / 1ps
// gbfp_byte_if and gbfp_frame_if: valid/ready channels of the frame parser
// no dependencies

interface gbfp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfp_frame_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  frame_kind;
   logic        [15:0] frame_type;
   logic signed [31:0] longitude;
   logic signed [31:0] latitude;

   modport source (output valid, output frame_kind, output frame_type,
                   output longitude, output latitude, input ready);
   modport sink   (input valid, input frame_kind, input frame_type,
                   input longitude, input latitude, output ready);
endinterface

// File: rtl/gbfp_frame_fsm.sv
`timescale 1ns / 1ps
// gbfp_frame_fsm: sync hunt, header decode and payload count, one byte a step
// depends on gbfp_pkg

module gbfp_frame_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                rx_byte,
   output gbfp_pkg::capture_ctrl_type cap_ctrl,
   output gbfp_pkg::frame_info_type   info
);

   gbfp_pkg::phase_type phase_ff, phase_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] offset_inc;
   logic        is_position;

   assign offset_inc  = offset_ff + 16'd1;
   assign is_position = (type_ff == gbfp_pkg::TYPE_POSITION);

   // next state and header registers
   always_comb begin
      phase_in  = phase_ff;
      type_in   = type_ff;
      length_in = length_ff;
      offset_in = offset_ff;
      unique case (phase_ff)
         gbfp_pkg::PH_SYNC1: begin
            if (rx_byte == gbfp_pkg::SYNC_FIRST) phase_in = gbfp_pkg::PH_SYNC2;
         end
         gbfp_pkg::PH_SYNC2: begin
            if (rx_byte == gbfp_pkg::SYNC_SECOND) begin
               phase_in = gbfp_pkg::PH_CLASS;
            end else if (rx_byte != gbfp_pkg::SYNC_FIRST) begin
               phase_in = gbfp_pkg::PH_SYNC1;
            end
         end
         gbfp_pkg::PH_CLASS: begin
            type_in  = {rx_byte, 8'h00};
            phase_in = gbfp_pkg::PH_ID;
         end
         gbfp_pkg::PH_ID: begin
            type_in  = {type_ff[15:8], rx_byte};
            phase_in = gbfp_pkg::PH_LEN_LO;
         end
         gbfp_pkg::PH_LEN_LO: begin
            length_in = {8'h00, rx_byte};
            phase_in  = gbfp_pkg::PH_LEN_HI;
         end
         gbfp_pkg::PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            offset_in = 16'd0;
            phase_in  = ({rx_byte, length_ff[7:0]} == 16'd0) ? gbfp_pkg::PH_CHK1
                                                              : gbfp_pkg::PH_PAYLOAD;
         end
         gbfp_pkg::PH_PAYLOAD: begin
            offset_in = offset_inc;
            if (offset_inc >= length_ff) phase_in = gbfp_pkg::PH_CHK1;
         end
         gbfp_pkg::PH_CHK1: phase_in = gbfp_pkg::PH_CHK2;
         gbfp_pkg::PH_CHK2: phase_in = gbfp_pkg::PH_SYNC1;
         default:           phase_in = gbfp_pkg::PH_SYNC1;
      endcase
   end

   // outputs
   always_comb begin
      cap_ctrl.clear  = (phase_ff == gbfp_pkg::PH_LEN_HI);
      cap_ctrl.lon_we = (phase_ff == gbfp_pkg::PH_PAYLOAD) && is_position &&
                        (offset_ff[15:2] == gbfp_pkg::LON_WORD);
      cap_ctrl.lat_we = (phase_ff == gbfp_pkg::PH_PAYLOAD) && is_position &&
                        (offset_ff[15:2] == gbfp_pkg::LAT_WORD);
      cap_ctrl.lane   = offset_ff[1:0];

      info.emit      = (phase_ff == gbfp_pkg::PH_CHK2);
      info.type_word = type_ff;
      if (is_position) begin
         info.kind = (length_ff >= gbfp_pkg::POS_NEED) ? gbfp_pkg::KIND_POSITION
                                                       : gbfp_pkg::KIND_SHORT;
      end else if (type_ff == gbfp_pkg::TYPE_STATUS) begin
         info.kind = gbfp_pkg::KIND_STATUS;
      end else begin
         info.kind = gbfp_pkg::KIND_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= gbfp_pkg::PH_SYNC1;
         type_ff   <= '0;
         length_ff <= '0;
         offset_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         offset_ff <= offset_in;
      end
   end

endmodule

// File: rtl/gbfp_pos_capture.sv
`timescale 1ns / 1ps
// gbfp_pos_capture: assembles little-endian longitude and latitude words
// depends on gbfp_pkg

module gbfp_pos_capture (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  gbfp_pkg::capture_ctrl_type cap_ctrl,
   output logic signed [31:0]         held_lon,
   output logic signed [31:0]         held_lat
);

   logic [31:0] lon_ff, lon_in;
   logic [31:0] lat_ff, lat_in;

   always_comb begin
      lon_in = lon_ff;
      lat_in = lat_ff;
      if (cap_ctrl.clear) begin
         lon_in = '0;
         lat_in = '0;
      end else begin
         case (cap_ctrl.lane)
            2'd0: begin
               if (cap_ctrl.lon_we) lon_in[7:0] = rx_byte;
               if (cap_ctrl.lat_we) lat_in[7:0] = rx_byte;
            end
            2'd1: begin
               if (cap_ctrl.lon_we) lon_in[15:8] = rx_byte;
               if (cap_ctrl.lat_we) lat_in[15:8] = rx_byte;
            end
            2'd2: begin
               if (cap_ctrl.lon_we) lon_in[23:16] = rx_byte;
               if (cap_ctrl.lat_we) lat_in[23:16] = rx_byte;
            end
            default: begin
               if (cap_ctrl.lon_we) lon_in[31:24] = rx_byte;
               if (cap_ctrl.lat_we) lat_in[31:24] = rx_byte;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lon_ff <= '0;
         lat_ff <= '0;
      end else if (step) begin
         lon_ff <= lon_in;
         lat_ff <= lat_in;
      end
   end

   assign held_lon = $signed(lon_ff);
   assign held_lat = $signed(lat_ff);

endmodule

// File: rtl/gbfp_out_stage.sv
`timescale 1ns / 1ps
// gbfp_out_stage: result register of the frame parser
// depends on gbfp_pkg and gbfp_if

module gbfp_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  gbfp_pkg::frame_info_type info,
   input  logic signed [31:0]       held_lon,
   input  logic signed [31:0]       held_lat,
   output logic                     full,
   gbfp_frame_if.source             rsp_ch
);

   logic               vld_ff;
   logic [1:0]         kind_ff;
   logic [15:0]        type_ff;
   logic signed [31:0] lon_ff;
   logic signed [31:0] lat_ff;
   logic               pos_ok;

   assign pos_ok = (info.kind == gbfp_pkg::KIND_POSITION);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (load) begin
         vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         vld_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= info.kind;
         type_ff <= info.type_word;
         lon_ff  <= pos_ok ? held_lon : 32'sd0;
         lat_ff  <= pos_ok ? held_lat : 32'sd0;
      end
   end

   assign full              = vld_ff;
   assign rsp_ch.valid      = vld_ff;
   assign rsp_ch.frame_kind = kind_ff;
   assign rsp_ch.frame_type = type_ff;
   assign rsp_ch.longitude  = lon_ff;
   assign rsp_ch.latitude   = lat_ff;

endmodule

// File: rtl/gnss_binary_frame_parser.sv
`timescale 1ns / 1ps
// gnss_binary_frame_parser: top level of the binary gnss frame parser
// depends on gbfp_pkg, gbfp_if, gbfp_frame_fsm, gbfp_pos_capture, gbfp_out_stage
//
// usage
//   req_ch carries the received serial stream, one byte per transfer. the block
//   hunts for sync bytes b5 62, reads class, id and a little-endian length,
//   counts the payload and skips two checksum bytes, which are not checked.
//   rsp_ch gives one transfer per completed frame: kind, class/id type and,
//   for a full position frame, longitude and latitude (zero otherwise).
//   a byte is held in the input register and processed from there; the result
//   of a frame is loaded into the result register when its last checksum byte
//   is processed. throughput: one byte per cycle, set by the single byte-wide
//   state step, unless a result waits on a stalled receiver, which holds back
//   the last checksum byte of the next frame and the bytes behind it; all
//   bytes before it keep flowing while a result waits.
//   reset (synchronous, active high) returns to sync hunting with cleared
//   header, count and position registers and drops any pending result.

module gnss_binary_frame_parser (
   input  logic         clock,
   input  logic         reset,
   gbfp_byte_if.sink    req_ch,
   gbfp_frame_if.source rsp_ch
);

   // input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   gbfp_pkg::capture_ctrl_type cap_ctrl;
   gbfp_pkg::frame_info_type   info;
   logic signed [31:0]         held_lon;
   logic signed [31:0]         held_lat;
   logic                       out_full;
   logic                       step;

   // a byte that completes a frame needs room in the result register
   assign step = in_vld_ff && (!info.emit || !out_full || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   gbfp_frame_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .cap_ctrl (cap_ctrl),
      .info     (info)
   );

   gbfp_pos_capture u_capture (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .cap_ctrl (cap_ctrl),
      .held_lon (held_lon),
      .held_lat (held_lat)
   );

   // result is loaded when the last checksum byte is processed
   gbfp_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (step && info.emit),
      .info     (info),
      .held_lon (held_lon),
      .held_lat (held_lat),
      .full     (out_full),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for gnss_binary_frame_parser, byte stream in, frame summaries out
// depends on gbfp_pkg, gbfp_byte_if, gbfp_frame_if and the parser rtl

module tb;

   // stimulus sizing and run limits
   localparam int BYTE_TARGET   = 1650;
   localparam int CALM_TAIL     = 150;     // last bytes go out with no idling on either side
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 10;

   // one frame summary as seen on the result channel
   typedef struct packed {
      logic        [1:0]  kind;
      logic        [15:0] ftype;
      logic signed [31:0] lon;
      logic signed [31:0] lat;
   } frame_summary_type;

   logic clock;
   logic reset;

   gbfp_byte_if  byte_ch ();
   gbfp_frame_if frame_ch ();

   gnss_binary_frame_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (byte_ch),
      .rsp_ch (frame_ch)
   );

   // bytes still to be sent and frame summaries still owed by the block
   logic [7:0]        stream_bytes[$];
   frame_summary_type expected_frames[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int bytes_total    = 0;
   int bytes_accepted = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   bit quiet_tail     = 1'b0;

   // shadow copy of the parser state, advanced once per accepted byte
   gbfp_pkg::phase_type shadow_phase;
   logic        [15:0]  shadow_type;
   logic        [15:0]  shadow_len;
   logic        [15:0]  shadow_offset;
   logic signed [31:0]  shadow_lon;
   logic signed [31:0]  shadow_lat;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // walk the frame grammar for one byte; a finished frame queues its summary
   task automatic track_byte(input logic [7:0] b);
      frame_summary_type summary;
      logic [15:0]       full_len;
      case (shadow_phase)
         gbfp_pkg::PH_SYNC1: begin
            if (b == gbfp_pkg::SYNC_FIRST)
               shadow_phase = gbfp_pkg::PH_SYNC2;
         end
         gbfp_pkg::PH_SYNC2: begin
            // a repeated first sync byte keeps us waiting for the second one
            if (b == gbfp_pkg::SYNC_SECOND)
               shadow_phase = gbfp_pkg::PH_CLASS;
            else if (b != gbfp_pkg::SYNC_FIRST)
               shadow_phase = gbfp_pkg::PH_SYNC1;
         end
         gbfp_pkg::PH_CLASS: begin
            shadow_type  = {b, 8'h00};
            shadow_phase = gbfp_pkg::PH_ID;
         end
         gbfp_pkg::PH_ID: begin
            shadow_type[7:0] = b;
            shadow_phase     = gbfp_pkg::PH_LEN_LO;
         end
         gbfp_pkg::PH_LEN_LO: begin
            shadow_len   = {8'h00, b};
            shadow_phase = gbfp_pkg::PH_LEN_HI;
         end
         gbfp_pkg::PH_LEN_HI: begin
            full_len      = {b, shadow_len[7:0]};
            shadow_len    = full_len;
            shadow_offset = '0;
            shadow_lon    = '0;
            shadow_lat    = '0;
            // empty payload goes straight to the checksum
            shadow_phase  = (full_len == 16'd0) ? gbfp_pkg::PH_CHK1 : gbfp_pkg::PH_PAYLOAD;
         end
         gbfp_pkg::PH_PAYLOAD: begin
            if (shadow_type == gbfp_pkg::TYPE_POSITION) begin
               if (shadow_offset[15:2] == gbfp_pkg::LON_WORD)
                  shadow_lon[{shadow_offset[1:0], 3'b000} +: 8] = b;
               else if (shadow_offset[15:2] == gbfp_pkg::LAT_WORD)
                  shadow_lat[{shadow_offset[1:0], 3'b000} +: 8] = b;
            end
            shadow_offset = shadow_offset + 16'd1;
            if (shadow_offset >= shadow_len)
               shadow_phase = gbfp_pkg::PH_CHK1;
         end
         gbfp_pkg::PH_CHK1: begin
            shadow_phase = gbfp_pkg::PH_CHK2;
         end
         gbfp_pkg::PH_CHK2: begin
            // checksum is never checked; the second byte closes the frame
            shadow_phase = gbfp_pkg::PH_SYNC1;
            if (shadow_type == gbfp_pkg::TYPE_POSITION)
               summary.kind = (shadow_len >= gbfp_pkg::POS_NEED) ? gbfp_pkg::KIND_POSITION
                                                                  : gbfp_pkg::KIND_SHORT;
            else if (shadow_type == gbfp_pkg::TYPE_STATUS)
               summary.kind = gbfp_pkg::KIND_STATUS;
            else
               summary.kind = gbfp_pkg::KIND_OTHER;
            summary.ftype = shadow_type;
            summary.lon   = (summary.kind == gbfp_pkg::KIND_POSITION) ? shadow_lon : '0;
            summary.lat   = (summary.kind == gbfp_pkg::KIND_POSITION) ? shadow_lat : '0;
            expected_frames.push_back(summary);
         end
         default: begin
            shadow_phase = gbfp_pkg::PH_SYNC1;
         end
      endcase
   endtask

   // coordinates lean toward the extremes of the signed range, zero and minus one
   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return $urandom();
      endcase
   endfunction

   // queue one well-formed frame with random payload and checksum bytes
   task automatic add_frame(input logic [15:0] ftype, input int len,
                            input logic signed [31:0] lon, input logic signed [31:0] lat,
                            input bit lead_sync);
      logic [7:0]  b;
      logic [15:0] len_field;
      len_field = len[15:0];
      if (lead_sync)
         stream_bytes.push_back(gbfp_pkg::SYNC_FIRST);
      stream_bytes.push_back(gbfp_pkg::SYNC_FIRST);
      stream_bytes.push_back(gbfp_pkg::SYNC_SECOND);
      stream_bytes.push_back(ftype[15:8]);
      stream_bytes.push_back(ftype[7:0]);
      stream_bytes.push_back(len_field[7:0]);
      stream_bytes.push_back(len_field[15:8]);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i >= 28 && i < 32)
            b = lon[8 * (i - 28) +: 8];
         else if (i >= 32 && i < 36)
            b = lat[8 * (i - 32) +: 8];
         stream_bytes.push_back(b);
      end
      stream_bytes.push_back(8'($urandom_range(0, 255)));
      stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // noise between frames stays clear of the first sync byte so that
   // stray headers cannot swallow the stream with a huge length
   task automatic add_noise(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom_range(0, 255));
         if (b == gbfp_pkg::SYNC_FIRST)
            b = ~b;
         stream_bytes.push_back(b);
      end
   endtask

   task automatic build_stream();
      logic [7:0]  b;
      logic [15:0] ftype;
      int          pick;
      bit          lead;

      // directed: extreme noise bytes, a broken sync pair, an empty status
      // frame behind a repeated first sync byte, a position frame too short
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(gbfp_pkg::SYNC_FIRST);
      stream_bytes.push_back(8'h00);
      add_frame(gbfp_pkg::TYPE_STATUS, 0, '0, '0, 1'b1);
      add_frame(gbfp_pkg::TYPE_POSITION, 2, '0, '0, 1'b0);

      // full position frames with both coordinates at opposite extremes
      add_frame(gbfp_pkg::TYPE_POSITION, 36, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
      add_frame(gbfp_pkg::TYPE_POSITION, 36, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);

      // random mix, mostly well-formed frames
      while (stream_bytes.size() < BYTE_TARGET) begin
         pick = $urandom_range(0, 99);
         lead = ($urandom_range(0, 7) == 0);
         if (pick < 40) begin
            add_frame(gbfp_pkg::TYPE_POSITION, $urandom_range(36, 48),
                      pick_coord(), pick_coord(), lead);
         end else if (pick < 50) begin
            add_frame(gbfp_pkg::TYPE_POSITION, $urandom_range(0, 35),
                      pick_coord(), pick_coord(), lead);
         end else if (pick < 65) begin
            add_frame(gbfp_pkg::TYPE_STATUS, $urandom_range(0, 12), '0, '0, lead);
         end else if (pick < 80) begin
            ftype = 16'($urandom_range(0, 65535));
            // now and then a length with the high byte set
            if ($urandom_range(0, 19) == 0)
               add_frame(ftype, $urandom_range(256, 300), '0, '0, lead);
            else
               add_frame(ftype, $urandom_range(0, 12), '0, '0, lead);
         end else if (pick < 90) begin
            add_noise($urandom_range(1, 6));
         end else begin
            // first sync byte followed by anything but a sync byte
            b = 8'($urandom_range(0, 255));
            if (b == gbfp_pkg::SYNC_SECOND || b == gbfp_pkg::SYNC_FIRST)
               b = 8'h00;
            stream_bytes.push_back(gbfp_pkg::SYNC_FIRST);
            stream_bytes.push_back(b);
         end
      end
      bytes_total = stream_bytes.size();
   endtask

   // byte driver: predicts on every transfer, refills the slot or idles in bursts
   always @(posedge clock) begin
      if (reset) begin
         byte_ch.valid <= 1'b0;
         byte_ch.rx_byte <= 8'h00;
         quiet_tail <= 1'b0;
      end else begin
         if (byte_ch.valid && byte_ch.ready) begin
            track_byte(byte_ch.rx_byte);
            bytes_accepted++;
         end
         quiet_tail <= (stream_bytes.size() < CALM_TAIL);
         if (!byte_ch.valid || byte_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               byte_ch.valid <= 1'b0;
            end else if (stream_bytes.size() == 0) begin
               byte_ch.valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
               // start an idle burst with this slot
               send_gap = $urandom_range(1, 10) - 1;
               byte_ch.valid <= 1'b0;
            end else begin
               byte_ch.valid <= 1'b1;
               byte_ch.rx_byte <= stream_bytes.pop_front();
            end
         end
      end
   end

   // result monitor: checks every transfer against the oldest summary owed,
   // and stalls the result channel in random bursts
   always @(posedge clock) begin
      frame_summary_type want;
      if (reset) begin
         frame_ch.ready <= 1'b0;
      end else begin
         if (frame_ch.valid && frame_ch.ready) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected frame, type %h kind %0d",
                                         frame_ch.frame_type, frame_ch.frame_kind));
            end else begin
               want = expected_frames.pop_front();
               if (frame_ch.frame_kind !== want.kind)
                  report_mismatch($sformatf("frame_kind %0d, want %0d (type %h)",
                                            frame_ch.frame_kind, want.kind, want.ftype));
               if (frame_ch.frame_type !== want.ftype)
                  report_mismatch($sformatf("frame_type %h, want %h",
                                            frame_ch.frame_type, want.ftype));
               if (frame_ch.longitude !== want.lon)
                  report_mismatch($sformatf("longitude %0d, want %0d (type %h)",
                                            frame_ch.longitude, want.lon, want.ftype));
               if (frame_ch.latitude !== want.lat)
                  report_mismatch($sformatf("latitude %0d, want %0d (type %h)",
                                            frame_ch.latitude, want.lat, want.ftype));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            frame_ch.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            frame_ch.ready <= 1'b0;
         end else begin
            frame_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int idle;
      // known values on every block input from time zero
      reset = 1'b1;
      byte_ch.valid = 1'b0;
      byte_ch.rx_byte = 8'h00;
      frame_ch.ready = 1'b0;
      // shadow state matches the block after reset
      shadow_phase  = gbfp_pkg::PH_SYNC1;
      shadow_type   = '0;
      shadow_len    = '0;
      shadow_offset = '0;
      shadow_lon    = '0;
      shadow_lat    = '0;

      build_stream();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every byte transferred
      while (bytes_accepted < bytes_total)
         @(posedge clock);

      // then every owed summary delivered, bounded
      idle = 0;
      while (expected_frames.size() > 0 && idle < DRAIN_LIMIT) begin
         @(posedge clock);
         idle++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_frames.size() > 0)
         report_mismatch($sformatf("%0d frames never delivered", expected_frames.size()));

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: gnss_binary_frame_parser.f
rtl/gbfp_pkg.sv
rtl/gbfp_if.sv
rtl/gbfp_frame_fsm.sv
rtl/gbfp_pos_capture.sv
rtl/gbfp_out_stage.sv
rtl/gnss_binary_frame_parser.sv
tb/tb.sv
